>>> src/trj_pkg.sv
// shared types and constants for the trajectory nearest point search
// no dependencies; imported by trj_scan, trj_isqrt and the top level
package trj_pkg;

   localparam int COORD_W   = 24;
   localparam int ANG_W     = 16;
   localparam int ENTRY_W   = 2 * COORD_W + 2 * ANG_W;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int ROOT_W    = 25;
   localparam int IDX_OUT_W = 10;
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 120;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // travels with each read through the distance pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

>>> src/trj_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module trj_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/trj_scan.sv
// distance pipeline and running minimum over the stored path
// depends on trj_pkg; fed from the read port of trj_ram
module trj_scan #(
   parameter int AW = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  trj_pkg::tag_type               issue_tag,
   input  logic [AW-1:0]                  issue_idx,
   input  logic [trj_pkg::ENTRY_W-1:0]    rd_data,
   input  logic signed [trj_pkg::COORD_W-1:0] qx,
   input  logic signed [trj_pkg::COORD_W-1:0] qy,
   output logic [AW-1:0]                  best_idx,
   output logic [trj_pkg::SQ_W-1:0]       end_dsq,
   output logic                           done
);
   import trj_pkg::*;

   // stage 1: aligned with ram read data
   tag_type tag1_ff;
   logic [AW-1:0] idx1_ff;
   // stage 2: coordinate differences
   tag_type tag2_ff;
   logic [AW-1:0] idx2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff, dx2_in, dy2_in;
   // stage 3: squares
   tag_type tag3_ff;
   logic [AW-1:0] idx3_ff;
   logic [SQ_W-2:0] sqx3_ff, sqy3_ff;
   logic signed [SQ_W-1:0] sqx_full, sqy_full;
   // stage 4: squared distance
   tag_type tag4_ff;
   logic [AW-1:0] idx4_ff;
   logic [SQ_W-1:0] d4_ff;
   // running minimum
   logic [SQ_W-1:0] best_d_ff, best_d_in, end_d_ff, end_d_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic done_ff, done_in;

   assign dx2_in = $signed({rd_data[COORD_W-1], rd_data[COORD_W-1:0]})
                 - $signed({qx[COORD_W-1], qx});
   assign dy2_in = $signed({rd_data[2*COORD_W-1], rd_data[2*COORD_W-1:COORD_W]})
                 - $signed({qy[COORD_W-1], qy});
   assign sqx_full = dx2_ff * dx2_ff;
   assign sqy_full = dy2_ff * dy2_ff;

   always_comb begin
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      end_d_in    = end_d_ff;
      done_in     = tag4_ff.valid & tag4_ff.last;
      if (tag4_ff.valid) begin
         // strict compare keeps the lowest index on a tie
         if (tag4_ff.first || (d4_ff < best_d_ff)) begin
            best_d_in   = d4_ff;
            best_idx_in = idx4_ff;
         end
         if (tag4_ff.last) begin
            end_d_in = d4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff     <= issue_idx;
      idx2_ff     <= idx1_ff;
      dx2_ff      <= dx2_in;
      dy2_ff      <= dy2_in;
      idx3_ff     <= idx2_ff;
      sqx3_ff     <= sqx_full[SQ_W-2:0];
      sqy3_ff     <= sqy_full[SQ_W-2:0];
      idx4_ff     <= idx3_ff;
      d4_ff       <= {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      end_d_ff    <= end_d_in;
   end

   assign best_idx = best_idx_ff;
   assign end_dsq  = end_d_ff;
   assign done     = done_ff;

endmodule

>>> src/trj_isqrt.sv
// bit-serial integer square root, one result bit per cycle
// depends on trj_pkg
module trj_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [trj_pkg::SQ_W-1:0]     radicand,
   output logic                         busy,
   output logic [trj_pkg::ROOT_W-1:0]   root
);
   import trj_pkg::*;

   localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (2 * (ROOT_W - 1));

   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   trial;

   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = TOP_BIT;
      end else if (bit_ff != '0) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[SQ_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (bit_ff != '0);
   assign root = root_ff[ROOT_W-1:0];

endmodule

>>> src/trajectory_nearest_point_search.sv
// top level of the trajectory nearest point search
// depends on trj_pkg, trj_ram, trj_scan and trj_isqrt
//
// usage
//  req channel: one beat either loads a path point (tuser op = load) or asks
//    for the nearest stored point to a position (op = query). a load with the
//    first flag set restarts the path at index 0; loads beyond MAX_POINTS are
//    dropped. a load gives no rsp beat.
//  rsp channel: one beat per query with the nearest point (lowest index on a
//    tie), its index, its stored fields and the floor square root of the
//    distance to the last stored point. an empty path gives status empty and
//    all data zero.
//  timing: a query reads the point memory once per cycle, one stored point
//    per read; a four stage distance pipeline, a re-read of the winning
//    entry and the bit-serial square root follow before the rsp beat is
//    ready. req_tready is low while a query is in progress.
//  stalls: the result sits in an output register; while it waits, loads and
//    the next query are still taken, and a second result waits until the
//    first beat has gone.
//  reset: empties the path; memory contents are not cleared and need not be.
module trajectory_nearest_point_search #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x [23:0], pos_y [47:24], heading [63:48], bend [79:64]
   input  logic [trj_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op [0], first [1]
   input  logic [trj_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // near_index [9:0], near_x [33:10], near_y [57:34], near_heading [73:58],
   // near_bend [89:74], end_distance [114:90], zero [119:115]
   output logic [trj_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status [0]
   output logic [0:0]                        rsp_tuser
);
   import trj_pkg::*;

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // request fields
   logic req_op, req_first, req_accept;
   assign req_op     = req_tuser[0];
   assign req_first  = req_tuser[1];
   assign req_accept = req_tvalid & req_tready;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             issue_ff, issue_in;
   logic [AW-1:0]    issue_idx_ff, issue_idx_in;
   logic [AW-1:0]    last_idx_ff, last_idx_in;
   logic             fetch_ff, fetch_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;

   // query payload
   logic signed [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic                res_status_ff, res_status_in;
   logic [AW-1:0]       res_idx_ff, res_idx_in;
   logic [ENTRY_W-1:0]  res_entry_ff, res_entry_in;
   logic [ROOT_W-1:0]   res_dist_ff, res_dist_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                rsp_tuser_ff, rsp_tuser_in;
   logic [AW+IDX_OUT_W-1:0] idx_wide;

   // memory port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   // scan and root
   tag_type          issue_tag;
   logic [AW-1:0]    best_idx;
   logic [SQ_W-1:0]  end_dsq;
   logic             scan_done;
   logic             sqrt_start, sqrt_busy;
   logic [ROOT_W-1:0] sqrt_root;

   trj_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[ENTRY_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trj_scan #(
      .AW (AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .issue_idx (issue_idx_ff),
      .rd_data   (rd_data),
      .qx        (qx_ff),
      .qy        (qy_ff),
      .best_idx  (best_idx),
      .end_dsq   (end_dsq),
      .done      (scan_done)
   );

   trj_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (end_dsq),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   assign req_tready = (state_ff == ST_IDLE);

   // one read per cycle during the scan, then the winner once more
   assign rd_addr = scan_done ? best_idx : issue_idx_ff;

   always_comb begin
      issue_tag.valid = issue_ff;
      issue_tag.first = (issue_idx_ff == '0);
      issue_tag.last  = (issue_idx_ff == last_idx_ff);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      issue_idx_in  = issue_idx_ff;
      last_idx_in   = last_idx_ff;
      fetch_in      = 1'b0;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_entry_in  = res_entry_ff;
      res_dist_in   = res_dist_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      sqrt_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_op == OP_LOAD) begin
                  if (req_first) begin
                     // restart the path with this point
                     wr_en    = 1'b1;
                     count_in = CNT_W'(1);
                  end else if (count_ff < CNT_W'(MAX_POINTS)) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  res_idx_in    = '0;
                  res_entry_in  = '0;
                  res_dist_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  qx_in         = req_tdata[COORD_W-1:0];
                  qy_in         = req_tdata[2*COORD_W-1:COORD_W];
                  issue_in      = 1'b1;
                  issue_idx_in  = '0;
                  last_idx_in   = AW'(count_ff - CNT_W'(1));
                  res_status_in = STATUS_OK;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               issue_idx_in = issue_idx_ff + AW'(1);
               if (issue_idx_ff == last_idx_ff) begin
                  issue_in = 1'b0;
               end
            end
            if (scan_done) begin
               // winner read goes out this cycle, root starts alongside
               sqrt_start = 1'b1;
               fetch_in   = 1'b1;
               res_idx_in = best_idx;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (fetch_ff) begin
               res_entry_in = rd_data;
            end
            if (!sqrt_busy && !fetch_ff) begin
               res_dist_in = sqrt_root;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = {{(RSP_DATA_W - IDX_OUT_W - ENTRY_W - ROOT_W){1'b0}},
                                res_dist_ff, res_entry_ff, idx_wide[IDX_OUT_W-1:0]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // index reported modulo 1024, zero-extended for short paths
   assign idx_wide = {{IDX_OUT_W{1'b0}}, res_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         issue_idx_ff  <= '0;
         last_idx_ff   <= '0;
         fetch_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         issue_idx_ff  <= issue_idx_in;
         last_idx_ff   <= last_idx_in;
         fetch_ff      <= fetch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_entry_ff  <= res_entry_in;
      res_dist_ff   <= res_dist_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_issue_in_scan: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> state_ff == ST_SCAN)
      else $error("memory read issued outside a scan");

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> state_ff == ST_SCAN && !issue_ff)
      else $error("scan finished while reads still pending");

   a_root_in_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_busy |-> state_ff == ST_ROOT)
      else $error("square root running outside its state");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tuser_ff == STATUS_EMPTY |-> rsp_tdata_ff == '0)
      else $error("empty path result carries data");

endmodule
